/* rtl/rmq_pkg.sv */
// Shared constants, types and helpers for the rotation matrix to quaternion block.
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

   // Component and input width (signed Q1.14)
   localparam int unsigned QW      = 16;
   localparam int unsigned GRD_W   = 15;
   localparam int unsigned DIF_W   = 18;
   localparam int unsigned SUM_W   = 19;
   localparam int unsigned T_W     = 17;
   localparam int unsigned RAD_W   = 48;
   localparam int unsigned ROOT_W  = 24;
   localparam int unsigned DEN_W   = ROOT_W + 1;
   localparam int unsigned MAG_W   = 18;
   localparam int unsigned ACC_W   = 41;
   localparam int unsigned QUO_W   = 16;
   localparam int unsigned RAW_W   = 20;
   localparam int unsigned AX_W    = 2;
   localparam int unsigned Q_ONE   = 16384;
   localparam int unsigned GRD_RST = 1;

   // Pipeline layout: prep, root stages, divider setup, divider stages, output
   localparam int unsigned SQ_BASE = 0;
   localparam int unsigned DV_BASE = SQ_BASE + ROOT_W + 1;
   localparam int unsigned OUT_STG = DV_BASE + QUO_W + 1;
   localparam int unsigned NST     = OUT_STG + 1;

   // Component slots
   localparam logic [AX_W-1:0] AXIS_X = 2'd0;
   localparam logic [AX_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AX_W-1:0] AXIS_Z = 2'd2;
   localparam logic [AX_W-1:0] AXIS_W = 2'd3;

   typedef logic signed [QW-1:0] q_type;

   typedef struct packed {
      logic [RAD_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
      logic                    pos;
      logic [AX_W-1:0]         axis;
      logic signed [DIF_W-1:0] dif0;
      logic signed [DIF_W-1:0] dif1;
      logic signed [DIF_W-1:0] dif2;
   } sq_stage_type;

   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [ACC_W-1:0]  acc;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   typedef struct packed {
      logic              use_div;
      logic              pos;
      logic [AX_W-1:0]   axis;
      logic [QW-1:0]     half;
      logic [DEN_W-1:0]  den;
      lane_type [2:0]    lane;
   } dv_stage_type;

   // Cyclic successor of a diagonal axis: x -> y -> z -> x
   function automatic logic [AX_W-1:0] next_axis(input logic [AX_W-1:0] a);
      logic [AX_W-1:0] r;
      case (a)
         AXIS_X:  r = AXIS_Y;
         AXIS_Y:  r = AXIS_Z;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/rmq_if.sv */
// Channel interfaces: matrix requests, quaternion responses, guard register writes.
`timescale 1ns / 1ps
`default_nettype none

interface rmq_req_if;
   import rmq_pkg::*;
   logic  valid;
   logic  ready;
   q_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_rsp_if;
   import rmq_pkg::*;
   logic  valid;
   logic  ready;
   q_type quat_x, quat_y, quat_z, quat_w;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface rmq_csr_if;
   import rmq_pkg::*;
   logic             valid;
   logic             ready;
   logic [GRD_W-1:0] guard_threshold;
   modport source (output valid, guard_threshold, input ready);
   modport sink   (input valid, guard_threshold, output ready);
endinterface

`default_nettype wire

/* rtl/rotation_matrix_to_quaternion.sv */
// Top level: pipelined rotation matrix to quaternion converter (Shepperd's method).
`timescale 1ns / 1ps
`default_nettype none

// Converts one 3x3 rotation matrix (signed Q1.14) per transaction into a quaternion
// X, Y, Z, W (signed Q1.14, rounded, saturated to +/-1.0). The pipeline takes a new
// matrix every cycle unless stalled and holds 43 register stages: one for the trace
// and axis choice, 24 for the square root (one root bit per stage), one for the
// divider setup and the small-root multiply, 16 for the three parallel dividers (one
// quotient bit per stage) and the output register. Every stage has its own valid bit
// and moves whenever the stage after it is empty or moving, so stalls on the response
// side fill bubbles and lose nothing. The guard register resets to 1; the user must
// write it only while no transaction is in flight, which the block does not enforce.
module rotation_matrix_to_quaternion (
   input  wire logic  clock,
   input  wire logic  reset,
   rmq_req_if.sink    req_chan,
   rmq_rsp_if.source  rsp_chan,
   rmq_csr_if.sink    csr_chan
);
   import rmq_pkg::*;

   logic [GRD_W-1:0]  guard_ff;
   logic [NST-1:0]    vld_ff;
   logic [NST:0]      adv;
   sq_stage_type      sq_ff [ROOT_W+1];
   sq_stage_type      sq_in [ROOT_W+1];
   dv_stage_type      dv_ff [QUO_W+1];
   dv_stage_type      dv_in [QUO_W+1];
   q_type             out_ff [4];
   q_type             out_in [4];

   // Prep stage signals
   logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [SUM_W-1:0] tr, t_raw, da, db, dd;
   logic [AX_W-1:0]         ax;

   // Saturate a magnitude to one and apply the sign
   function automatic q_type sat_sign(input logic neg, input logic [RAW_W-1:0] mag);
      logic [QW-1:0] m;
      m = (mag > RAW_W'(Q_ONE)) ? QW'(Q_ONE) : mag[QW-1:0];
      return neg ? -q_type'(m) : q_type'(m);
   endfunction

   // Guard register write
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff <= GRD_W'(GRD_RST);
      end else if (csr_chan.valid) begin
         guard_ff <= csr_chan.guard_threshold;
      end
   end

   // Advance chain: a stage loads when empty or when its successor loads
   always_comb begin
      adv[NST] = rsp_chan.ready;
      for (int n = NST - 1; n >= 0; n--) begin
         adv[n] = !vld_ff[n] || adv[n+1];
      end
   end
   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int n = 1; n < NST; n++) begin
            if (adv[n]) begin
               vld_ff[n] <= vld_ff[n-1];
            end
         end
      end
   end

   // Prep: trace, pivot axis, radicand and off-diagonal terms
   always_comb begin
      e00 = SUM_W'(req_chan.m00);
      e01 = SUM_W'(req_chan.m01);
      e02 = SUM_W'(req_chan.m02);
      e10 = SUM_W'(req_chan.m10);
      e11 = SUM_W'(req_chan.m11);
      e12 = SUM_W'(req_chan.m12);
      e20 = SUM_W'(req_chan.m20);
      e21 = SUM_W'(req_chan.m21);
      e22 = SUM_W'(req_chan.m22);
      tr  = e00 + e11 + e22;
      ax  = AXIS_X;
      if (e11 > e00) begin
         ax = AXIS_Y;
      end
      if ((ax == AXIS_Y) ? (e22 > e11) : (e22 > e00)) begin
         ax = AXIS_Z;
      end
      sq_in[0].pos  = (tr > 0);
      sq_in[0].axis = ax;
      if (tr > 0) begin
         t_raw = tr + SUM_W'(Q_ONE);
         da    = e12 - e21;
         db    = e20 - e02;
         dd    = e01 - e10;
      end else begin
         case (ax)
            AXIS_X: begin
               t_raw = e00 - (e11 + e22) + SUM_W'(Q_ONE);
               da    = e12 - e21;
               db    = e01 + e10;
               dd    = e02 + e20;
            end
            AXIS_Y: begin
               t_raw = e11 - (e22 + e00) + SUM_W'(Q_ONE);
               da    = e20 - e02;
               db    = e12 + e21;
               dd    = e10 + e01;
            end
            default: begin
               t_raw = e22 - (e00 + e11) + SUM_W'(Q_ONE);
               da    = e01 - e10;
               db    = e20 + e02;
               dd    = e21 + e12;
            end
         endcase
      end
      // clamp a negative radicand to zero; radicand is shifted left by 30
      sq_in[0].rem  = (t_raw > 0) ? {1'b0, t_raw[T_W-1:0], 30'b0} : '0;
      sq_in[0].root = '0;
      sq_in[0].dif0 = da[DIF_W-1:0];
      sq_in[0].dif1 = db[DIF_W-1:0];
      sq_in[0].dif2 = dd[DIF_W-1:0];
   end

   // Square root: one result bit per stage, most significant first
   for (genvar n = 0; n < ROOT_W; n++) begin : g_root
      localparam int unsigned B = ROOT_W - 1 - n;
      logic [RAD_W-1:0] cand;
      always_comb begin
         cand = (RAD_W'(sq_ff[n].root) << (B + 1)) + (RAD_W'(1) << (2 * B));
         sq_in[n+1] = sq_ff[n];
         if (sq_ff[n].rem >= cand) begin
            sq_in[n+1].rem     = sq_ff[n].rem - cand;
            sq_in[n+1].root[B] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n <= ROOT_W; n++) begin
         if (adv[SQ_BASE+n]) begin
            sq_ff[n] <= sq_in[n];
         end
      end
   end

   // Divider setup: pick scale mode, form numerators or small-root products
   logic [ROOT_W-1:0]       s_root;
   logic                    s_div;
   logic signed [DIF_W-1:0] s_dif [3];
   logic [MAG_W-1:0]        s_mag [3];
   logic [ACC_W-1:0]        s_num [3];
   always_comb begin
      s_root   = sq_ff[ROOT_W].root;
      s_dif[0] = sq_ff[ROOT_W].dif0;
      s_dif[1] = sq_ff[ROOT_W].dif1;
      s_dif[2] = sq_ff[ROOT_W].dif2;
      s_div    = sq_ff[ROOT_W].pos || (s_root > ROOT_W'({guard_ff, 8'b0}));
      dv_in[0].use_div = s_div;
      dv_in[0].pos     = sq_ff[ROOT_W].pos;
      dv_in[0].axis    = sq_ff[ROOT_W].axis;
      dv_in[0].half    = QW'((DEN_W'(s_root) + DEN_W'(256)) >> 9);
      dv_in[0].den     = {s_root, 1'b0};
      for (int l = 0; l < 3; l++) begin
         s_mag[l] = s_dif[l][DIF_W-1] ? MAG_W'(-s_dif[l]) : MAG_W'(s_dif[l]);
         s_num[l] = ACC_W'({s_mag[l], 22'b0}) + ACC_W'(s_root);
         dv_in[0].lane[l].neg = s_dif[l][DIF_W-1];
         dv_in[0].lane[l].quo = '0;
         if (s_div) begin
            dv_in[0].lane[l].acc = s_num[l];
            dv_in[0].lane[l].ovf = (s_num[l] >= {s_root, 1'b0, 16'b0});
         end else begin
            dv_in[0].lane[l].acc = ACC_W'(s_mag[l] * s_root);
            dv_in[0].lane[l].ovf = 1'b0;
         end
      end
   end

   // Restoring division: one quotient bit per stage in each lane
   for (genvar n = 0; n < QUO_W; n++) begin : g_div
      localparam int unsigned B = QUO_W - 1 - n;
      logic [ACC_W-1:0] dsh;
      always_comb begin
         dsh = ACC_W'(dv_ff[n].den) << B;
         dv_in[n+1] = dv_ff[n];
         for (int l = 0; l < 3; l++) begin
            if (dv_ff[n].use_div && (dv_ff[n].lane[l].acc >= dsh)) begin
               dv_in[n+1].lane[l].acc    = dv_ff[n].lane[l].acc - dsh;
               dv_in[n+1].lane[l].quo[B] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n <= QUO_W; n++) begin
         if (adv[DV_BASE+n]) begin
            dv_ff[n] <= dv_in[n];
         end
      end
   end

   // Output: round, saturate and route the components
   logic [RAW_W-1:0] f_mag [3];
   q_type            f_val [3];
   q_type            f_half;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_ff[QUO_W].use_div) begin
            f_mag[l] = dv_ff[QUO_W].lane[l].ovf ? RAW_W'(Q_ONE + 1)
                                                : RAW_W'(dv_ff[QUO_W].lane[l].quo);
         end else begin
            f_mag[l] = RAW_W'((dv_ff[QUO_W].lane[l].acc + (ACC_W'(1) << 21)) >> 22);
         end
         f_val[l] = sat_sign(dv_ff[QUO_W].lane[l].neg, f_mag[l]);
      end
      f_half = sat_sign(1'b0, RAW_W'(dv_ff[QUO_W].half));
      if (dv_ff[QUO_W].pos) begin
         out_in[AXIS_X] = f_val[0];
         out_in[AXIS_Y] = f_val[1];
         out_in[AXIS_Z] = f_val[2];
         out_in[AXIS_W] = f_half;
      end else begin
         out_in[AXIS_W] = f_val[0];
         out_in[AXIS_X] = f_half;
         out_in[AXIS_Y] = f_half;
         out_in[AXIS_Z] = f_half;
         out_in[next_axis(dv_ff[QUO_W].axis)]            = f_val[1];
         out_in[next_axis(next_axis(dv_ff[QUO_W].axis))] = f_val[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STG]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid  = vld_ff[OUT_STG];
   assign rsp_chan.quat_x = out_ff[AXIS_X];
   assign rsp_chan.quat_y = out_ff[AXIS_Y];
   assign rsp_chan.quat_z = out_ff[AXIS_Z];
   assign rsp_chan.quat_w = out_ff[AXIS_W];

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps

module tb;
   import rmq_pkg::*;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [15:0] x, y, z, w;
   } quat_type;

   localparam int LATENCY = 43;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if req_chan();
   rmq_rsp_if rsp_chan();
   rmq_csr_if csr_chan();

   rotation_matrix_to_quaternion i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #5 clock = ~clock;

   matrix_type pending_mats [$];
   quat_type   expected_quats [$];
   logic [14:0] guard_model;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int mismatches = 0;
   int failed = 0;

   // Integer square root, floor
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned root22(input longint t);
      if (t <= 0) return 0;
      return int_sqrt(longint'(t) << 30);
   endfunction

   function automatic longint recip_term(input longint v, input longint unsigned s);
      longint unsigned mag, q;
      mag = (v < 0) ? -v : v;
      q = (2 * (mag << 21) + s) / (2 * s);
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint prod_term(input longint v, input longint unsigned s);
      longint unsigned mag, q;
      mag = (v < 0) ? -v : v;
      q = (mag * s + (64'd1 << 21)) >> 22;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Clamp to +/-1.0 with a signed compare on both sides
   function automatic logic signed [15:0] clamp_unit(input longint v);
      if (v > longint'(Q_ONE)) v = longint'(Q_ONE);
      if (v < -longint'(Q_ONE)) v = -longint'(Q_ONE);
      return v[15:0];
   endfunction

   // Shepperd conversion of one matrix under the current guard
   function automatic quat_type quat_of(input matrix_type mt);
      longint m [3][3];
      longint q [4];
      longint tr, a, b, d;
      longint unsigned s;
      int i, j, k;
      quat_type r;
      for (int n = 0; n < 9; n++) m[n / 3][n % 3] = mt.m[n];
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         s = root22(tr + Q_ONE);
         q[3] = (s + 256) >> 9;
         q[0] = recip_term(m[1][2] - m[2][1], s);
         q[1] = recip_term(m[2][0] - m[0][2], s);
         q[2] = recip_term(m[0][1] - m[1][0], s);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         s = root22(m[i][i] - (m[j][j] + m[k][k]) + Q_ONE);
         q[i] = (s + 256) >> 9;
         a = m[j][k] - m[k][j];
         b = m[i][j] + m[j][i];
         d = m[i][k] + m[k][i];
         if (s > (longint'(guard_model) << 8)) begin
            q[3] = recip_term(a, s);
            q[j] = recip_term(b, s);
            q[k] = recip_term(d, s);
         end else begin
            q[3] = prod_term(a, s);
            q[j] = prod_term(b, s);
            q[k] = prod_term(d, s);
         end
      end
      r.x = clamp_unit(q[0]);
      r.y = clamp_unit(q[1]);
      r.z = clamp_unit(q[2]);
      r.w = clamp_unit(q[3]);
      return r;
   endfunction

   // Driver: offer queued matrices, idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_quats.push_back(quat_of(pending_mats.pop_front()));
         end
         if (pending_mats.size() > 0 &&
             ((req_chan.valid && !req_chan.ready) ||
              $urandom_range(99) >= send_idle_pct)) begin
            req_chan.valid <= 1'b1;
            req_chan.m00 <= pending_mats[0].m[0];
            req_chan.m01 <= pending_mats[0].m[1];
            req_chan.m02 <= pending_mats[0].m[2];
            req_chan.m10 <= pending_mats[0].m[3];
            req_chan.m11 <= pending_mats[0].m[4];
            req_chan.m12 <= pending_mats[0].m[5];
            req_chan.m20 <= pending_mats[0].m[6];
            req_chan.m21 <= pending_mats[0].m[7];
            req_chan.m22 <= pending_mats[0].m[8];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted down here
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // Monitor: stall at random, compare each response with the oldest expectation
   always @(posedge clock) begin
      quat_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_quats.size() == 0) begin
               failed = 1;
               if (mismatches < 10) $display("unexpected response at %0t", $realtime);
               mismatches++;
            end else begin
               e = expected_quats.pop_front();
               if (e.x !== rsp_chan.quat_x || e.y !== rsp_chan.quat_y ||
                   e.z !== rsp_chan.quat_z || e.w !== rsp_chan.quat_w) begin
                  failed = 1;
                  if (mismatches < 10)
                     $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                              e.x, e.y, e.z, e.w, rsp_chan.quat_x, rsp_chan.quat_y,
                              rsp_chan.quat_z, rsp_chan.quat_w);
                  mismatches++;
               end
            end
         end
         rsp_chan.ready <= (hold_cycles <= 1) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [15:0] rand_entry();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         3: return 16'sd0;
         default: return 16'($signed(17'($urandom_range(32768)) - 17'sd16384));
      endcase
   endfunction

   // Random orthonormal-ish matrix from a random unit quaternion
   function automatic matrix_type rand_rotation();
      real a, b, c, d, n;
      matrix_type mt;
      a = $itor($urandom_range(2000)) - 1000.0;
      b = $itor($urandom_range(2000)) - 1000.0;
      c = $itor($urandom_range(2000)) - 1000.0;
      d = $itor($urandom_range(2000)) - 1000.0;
      n = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
      a /= n; b /= n; c /= n; d /= n;
      mt.m[0] = 16'($rtoi(16384.0 * (1 - 2*(c*c + d*d))));
      mt.m[1] = 16'($rtoi(16384.0 * 2*(b*c - a*d)));
      mt.m[2] = 16'($rtoi(16384.0 * 2*(b*d + a*c)));
      mt.m[3] = 16'($rtoi(16384.0 * 2*(b*c + a*d)));
      mt.m[4] = 16'($rtoi(16384.0 * (1 - 2*(b*b + d*d))));
      mt.m[5] = 16'($rtoi(16384.0 * 2*(c*d - a*b)));
      mt.m[6] = 16'($rtoi(16384.0 * 2*(b*d - a*c)));
      mt.m[7] = 16'($rtoi(16384.0 * 2*(c*d + a*b)));
      mt.m[8] = 16'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
      return mt;
   endfunction

   task automatic add_diag(input int d0, input int d1, input int d2, input int off);
      matrix_type mt;
      for (int n = 0; n < 9; n++) mt.m[n] = 16'(off * (n + 1) - 5 * off);
      mt.m[0] = 16'(d0); mt.m[4] = 16'(d1); mt.m[8] = 16'(d2);
      pending_mats.push_back(mt);
   endtask

   task automatic drain();
      wait (pending_mats.size() == 0 && expected_quats.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_guard(input logic [14:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.guard_threshold <= value;
      do @(posedge clock); while (!csr_chan.ready);
      guard_model = value;
      csr_chan.valid <= 1'b0;
   endtask

   task automatic add_random(input int count);
      for (int n = 0; n < count; n++) begin
         matrix_type mt;
         if ($urandom_range(3) != 0) begin
            mt = rand_rotation();
         end else begin
            for (int e = 0; e < 9; e++) mt.m[e] = rand_entry();
         end
         pending_mats.push_back(mt);
      end
   endtask

   initial begin
      int guards [5];
      guard_model = 15'(GRD_RST);
      req_chan.valid = 1'b0;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11} = '0;
      {req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.guard_threshold = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, each axis branch, ties, negative radicand, extremes
      add_diag(16384, 16384, 16384, 0);
      add_diag(16384, -16384, -16384, 0);
      add_diag(-16384, 16384, -16384, 0);
      add_diag(-16384, -16384, 16384, 0);
      add_diag(0, 0, 0, 0);
      add_diag(-100, -100, -100, 300);
      add_diag(-5000, -5000, 0, 7);
      add_diag(-20000, -20000, -20000, 9000);
      add_diag(-32768, 32767, 32767, -32768);
      add_diag(-16384, -16384, -16384, 16384);
      add_diag(-16383, -16384, -16384, 32767);
      add_diag(1, 0, -1, -32768);
      add_diag(32767, 32767, 32767, 32767);
      add_diag(-32768, -32768, -32768, -1);
      drain();

      // Phases of guard settings and idling
      guards = '{0, 16384, 1, 32767, 300};
      for (int p = 0; p < 5; p++) begin
         write_guard(15'(guards[p]));
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            3: begin send_idle_pct = 30; recv_stall_pct = 30; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (p == 4) hold_cycles = 300;
         add_diag(-16384, 16384, -16384, 1);
         add_diag(-16384, -16384, 16384, 2);
         add_random(320);
         drain();
      end

      if (failed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rotation_matrix_to_quaternion.sv
bench/tb.sv
